### src/lsmu_pkg.sv
// Shared types and codes of the load/store/move unit.
package lsmu_pkg;

    typedef enum logic [2:0] {
        OP_LD    = 3'd0,
        OP_ST    = 3'd1,
        OP_LDR   = 3'd2,
        OP_STR   = 3'd3,
        OP_MOVL  = 3'd4,
        OP_MOVLZ = 3'd5,
        OP_MOVH  = 3'd6
    } lsmu_op_t;

    // Addressing mode codes: bit 2 pre, bit 1 decrement, bit 0 increment
    localparam logic [2:0] AM_NONE    = 3'd0;
    localparam logic [2:0] AM_POSTINC = 3'd1;
    localparam logic [2:0] AM_POSTDEC = 3'd2;
    localparam logic [2:0] AM_PREINC  = 3'd5;
    localparam logic [2:0] AM_PREDEC  = 3'd6;

    localparam logic [15:0] WORD_STEP = 16'd2;
    localparam logic [15:0] BYTE_STEP = 16'd1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_LOAD = 2'd2
    } lsmu_state_t;

    // Request from the sequencer to the byte memory
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic        byte_sz;
        logic [15:0] addr;
        logic [15:0] wdata;
    } lsmu_mem_req_t;

endpackage

### src/lsmu_byte_mem.sv
// Little-endian byte memory built from an even and an odd byte bank.
module lsmu_byte_mem
    import lsmu_pkg::*;
#(
    parameter int MEM_ADDR_BITS = 16
)
(
    input  logic          clk,
    input  lsmu_mem_req_t req,
    output logic [15:0]   rdata
);

    localparam int ROW_W = MEM_ADDR_BITS - 1;
    localparam int ROWS  = 1 << ROW_W;

    logic [7:0] even_mem [ROWS];
    logic [7:0] odd_mem  [ROWS];

    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row_inc;
    logic [ROW_W-1:0] even_addr;
    logic             lane;
    logic             even_we;
    logic             odd_we;
    logic [7:0]       even_wd;
    logic [7:0]       odd_wd;

    logic [7:0] even_q_reg;
    logic [7:0] odd_q_reg;
    logic       lane_reg;
    logic       byte_reg;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;

    // Low byte sits in the bank picked by address bit 0; an odd word spills into the next row
    always_comb
    begin
        lane      = req.addr[0];
        row       = req.addr[MEM_ADDR_BITS-1:1];
        row_inc   = row + 1'b1;
        even_addr = lane ? row_inc : row;
        even_we   = req.wr && (!lane || !req.byte_sz);
        odd_we    = req.wr && (lane || !req.byte_sz);
        even_wd   = lane ? req.wdata[15:8] : req.wdata[7:0];
        odd_wd    = lane ? req.wdata[7:0]  : req.wdata[15:8];
    end

    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            even_mem[even_addr] <= even_wd;
        end
        if (req.rd)
        begin
            even_q_reg <= even_mem[even_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (odd_we)
        begin
            odd_mem[row] <= odd_wd;
        end
        if (req.rd)
        begin
            odd_q_reg <= odd_mem[row];
            lane_reg  <= lane;
            byte_reg  <= req.byte_sz;
        end
    end

    always_comb
    begin
        lo_byte = lane_reg ? odd_q_reg  : even_q_reg;
        hi_byte = lane_reg ? even_q_reg : odd_q_reg;
        rdata   = byte_reg ? {8'h00, lo_byte} : {hi_byte, lo_byte};
    end

endmodule

### src/load_store_move_unit.sv
// Load/store/move unit: register file, byte memory and instruction sequencer.
// Sequencing: an accepted transaction enters ST_EXEC, and a store, move or no-op is then
//   strobed on the registered done; loads pass through ST_LOAD for the synchronous memory read.
// Issue: a new start is taken in the done cycle; no new transaction is taken while busy.
// Reset: the register file reads as zero through per-entry valid bits; the byte memory
//   is not cleared and needs no clearing pass. done has no back-pressure.
module load_store_move_unit
    import lsmu_pkg::*;
#(
    parameter int NUM_REGS      = 8,
    parameter int MEM_ADDR_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [2:0]  addr_mode,
    input  logic        byte_size,
    input  logic [2:0]  source_reg,
    input  logic [2:0]  dest_reg,
    input  logic [5:0]  offset6,
    input  logic [7:0]  imm_byte,
    output logic        done,
    output logic [15:0] eff_addr,
    output logic [15:0] mem_value,
    output logic [15:0] dest_value,
    output logic [15:0] base_value,
    output logic        executed
);

    localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [15:0] ADDR_MASK = 16'((32'd1 << MEM_ADDR_BITS) - 32'd1);

    // Fold a 3-bit register field onto the implemented registers (one compare/subtract)
    function automatic logic [RIDX_W-1:0] reg_idx(input logic [2:0] v);
        logic [4:0] w;
        begin
            w = {2'b00, v};
            if (w >= 5'(NUM_REGS))
            begin
                w = w - 5'(NUM_REGS);
            end
            return w[RIDX_W-1:0];
        end
    endfunction

    // ---------------------------------------------------------------
    // Sequencer state and latched transaction
    // ---------------------------------------------------------------
    lsmu_state_t state_reg;
    lsmu_state_t state_next;
    logic        accept;

    logic [2:0]        op_reg;
    logic [2:0]        mode_reg;
    logic              byte_reg;
    logic [RIDX_W-1:0] s_idx_reg;
    logic [RIDX_W-1:0] d_idx_reg;
    logic [5:0]        off_reg;
    logic [7:0]        imm_reg;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            mode_reg  <= addr_mode;
            byte_reg  <= byte_size;
            s_idx_reg <= reg_idx(source_reg);
            d_idx_reg <= reg_idx(dest_reg);
            off_reg   <= offset6;
            imm_reg   <= imm_byte;
        end
    end

    // ---------------------------------------------------------------
    // Register file: one write port, two registered read ports
    // ---------------------------------------------------------------
    logic [15:0]         rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [15:0]         rs_raw_reg;
    logic [15:0]         rd_raw_reg;
    logic                rs_vld_reg;
    logic                rd_vld_reg;
    logic                rf_we;
    logic [RIDX_W-1:0]   rf_waddr;
    logic [15:0]         rf_wdata;

    // Read both operands when the transaction is taken; writes never land in that cycle
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (accept)
        begin
            rs_raw_reg <= rf_mem[reg_idx(source_reg)];
            rd_raw_reg <= rf_mem[reg_idx(dest_reg)];
        end
    end

    // Valid bits stand in for the zero reset of the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            rs_vld_reg   <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (accept)
            begin
                rs_vld_reg <= rf_valid_reg[reg_idx(source_reg)];
                rd_vld_reg <= rf_valid_reg[reg_idx(dest_reg)];
            end
        end
    end

    // ---------------------------------------------------------------
    // Byte memory
    // ---------------------------------------------------------------
    lsmu_mem_req_t mem_req;
    logic [15:0]   mem_rdata;

    lsmu_byte_mem #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // Datapath: address generation, store data and load merge
    // ---------------------------------------------------------------
    logic [15:0] rs_val;
    logic [15:0] rd_val;
    logic        is_ldst;
    logic        mode_ok;
    logic        op_known;
    logic        is_noop;
    logic        is_load;
    logic        modify;
    logic        pre;
    logic        dec;
    logic        same_reg;
    logic [15:0] step;
    logic [15:0] off16;
    logic [15:0] base_old;
    logic [15:0] base_adj;
    logic [15:0] base_pre;
    logic [15:0] base_fin;
    logic [15:0] ea16;
    logic [15:0] ea_m;
    logic [15:0] st_src;
    logic [15:0] st_mv;
    logic [15:0] old_d;
    logic [15:0] loaded;
    logic [15:0] d_fin;
    logic [15:0] ld_base;
    logic [15:0] mov_val;

    always_comb
    begin
        rs_val   = rs_vld_reg ? rs_raw_reg : 16'h0000;
        rd_val   = rd_vld_reg ? rd_raw_reg : 16'h0000;
        is_ldst  = (op_reg == OP_LD) || (op_reg == OP_ST);
        mode_ok  = (mode_reg == AM_NONE) || (mode_reg == AM_POSTINC)
                || (mode_reg == AM_POSTDEC) || (mode_reg == AM_PREINC)
                || (mode_reg == AM_PREDEC);
        op_known = is_ldst || (op_reg == OP_LDR) || (op_reg == OP_STR)
                || (op_reg == OP_MOVL) || (op_reg == OP_MOVLZ) || (op_reg == OP_MOVH);
        is_noop  = !op_known || (is_ldst && !mode_ok);
        is_load  = !is_noop && ((op_reg == OP_LD) || (op_reg == OP_LDR));
        modify   = (mode_reg != AM_NONE);
        pre      = mode_reg[2];
        dec      = mode_reg[1];
        same_reg = (s_idx_reg == d_idx_reg);
        step     = byte_reg ? BYTE_STEP : WORD_STEP;
        off16    = {{10{off_reg[5]}}, off_reg};

        // LD uses the source register as base, ST the destination register
        base_old = (op_reg == OP_LD) ? rs_val : rd_val;
        base_adj = dec ? (base_old - step) : (base_old + step);
        base_pre = (modify && pre) ? base_adj : base_old;
        base_fin = modify ? base_adj : base_old;

        if (is_ldst)
        begin
            ea16 = base_pre;
        end
        else if (op_reg == OP_LDR)
        begin
            ea16 = rs_val + off16;
        end
        else
        begin
            ea16 = rd_val + off16;
        end
        ea_m = ea16 & ADDR_MASK;

        // A pre-modified ST whose data register is the base stores the new base
        st_src = (op_reg == OP_ST && modify && pre && same_reg) ? base_adj : rs_val;
        st_mv  = byte_reg ? {8'h00, st_src[7:0]} : st_src;

        // Load merge: byte loads keep the high byte of the destination as it stands then
        old_d  = (op_reg == OP_LD && same_reg) ? base_pre : rd_val;
        loaded = byte_reg ? {old_d[15:8], mem_rdata[7:0]} : mem_rdata;
        // Post-modify of the loaded register itself applies after the load
        if (op_reg == OP_LD && modify && !pre && same_reg)
        begin
            d_fin = dec ? (loaded - step) : (loaded + step);
        end
        else
        begin
            d_fin = loaded;
        end
        if (same_reg)
        begin
            ld_base = d_fin;
        end
        else if (op_reg == OP_LD)
        begin
            ld_base = base_fin;
        end
        else
        begin
            ld_base = rs_val;
        end

        if (op_reg == OP_MOVL)
        begin
            mov_val = {rd_val[15:8], imm_reg};
        end
        else if (op_reg == OP_MOVLZ)
        begin
            mov_val = {8'h00, imm_reg};
        end
        else
        begin
            mov_val = {imm_reg, rd_val[7:0]};
        end
    end

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = is_load ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Output logic: register-file writes, memory requests, result
    // ---------------------------------------------------------------
    logic        done_reg;
    logic        done_next;
    logic [15:0] eff_addr_reg;
    logic [15:0] eff_addr_next;
    logic [15:0] mem_value_reg;
    logic [15:0] mem_value_next;
    logic [15:0] dest_value_reg;
    logic [15:0] dest_value_next;
    logic [15:0] base_value_reg;
    logic [15:0] base_value_next;
    logic        executed_reg;
    logic        executed_next;

    always_comb
    begin
        rf_we           = 1'b0;
        rf_waddr        = d_idx_reg;
        rf_wdata        = mov_val;
        mem_req         = '0;
        mem_req.byte_sz = byte_reg;
        mem_req.addr    = ea_m;
        mem_req.wdata   = st_mv;
        done_next       = 1'b0;
        eff_addr_next   = eff_addr_reg;
        mem_value_next  = mem_value_reg;
        dest_value_next = dest_value_reg;
        base_value_next = base_value_reg;
        executed_next   = executed_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                done_next       = !is_load;
                eff_addr_next   = 16'h0000;
                mem_value_next  = 16'h0000;
                dest_value_next = 16'h0000;
                base_value_next = 16'h0000;
                executed_next   = !is_noop;
                if (!is_noop)
                begin
                    priority case (op_reg)
                        OP_LD, OP_ST:
                        begin
                            // Write back the modified base now; a load may overwrite it later
                            rf_we    = modify;
                            rf_waddr = (op_reg == OP_LD) ? s_idx_reg : d_idx_reg;
                            rf_wdata = base_adj;
                            mem_req.rd = (op_reg == OP_LD);
                            mem_req.wr = (op_reg == OP_ST);
                            eff_addr_next   = ea_m;
                            mem_value_next  = st_mv;
                            dest_value_next = base_fin;
                            base_value_next = base_fin;
                        end
                        OP_LDR:
                        begin
                            mem_req.rd = 1'b1;
                        end
                        OP_STR:
                        begin
                            mem_req.wr      = 1'b1;
                            eff_addr_next   = ea_m;
                            mem_value_next  = st_mv;
                            dest_value_next = rd_val;
                            base_value_next = rd_val;
                        end
                        default:
                        begin
                            // Byte moves
                            rf_we           = 1'b1;
                            rf_waddr        = d_idx_reg;
                            rf_wdata        = mov_val;
                            dest_value_next = mov_val;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                rf_we           = 1'b1;
                rf_waddr        = d_idx_reg;
                rf_wdata        = d_fin;
                done_next       = 1'b1;
                eff_addr_next   = ea_m;
                mem_value_next  = mem_rdata;
                dest_value_next = d_fin;
                base_value_next = ld_base;
                executed_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold the result between transactions
    always_ff @(posedge clk)
    begin
        eff_addr_reg   <= eff_addr_next;
        mem_value_reg  <= mem_value_next;
        dest_value_reg <= dest_value_next;
        base_value_reg <= base_value_next;
        executed_reg   <= executed_next;
    end

    assign done       = done_reg;
    assign eff_addr   = eff_addr_reg;
    assign mem_value  = mem_value_reg;
    assign dest_value = dest_value_reg;
    assign base_value = base_value_reg;
    assign executed   = executed_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while a transaction is still in flight");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter execution");

    a_load_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> ($past(state_reg) == ST_EXEC))
        else $error("load completion without an execute cycle");

    a_rf_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> busy)
        else $error("register file written outside a transaction");

endmodule

### test/tb_load_store_move_unit.sv
// Testbench for load_store_move_unit: directed and random instruction transactions.
`timescale 1ns / 1ps

module tb_load_store_move_unit
    import lsmu_pkg::*;
();

    localparam int NUM_REGS      = 8;
    localparam int MEM_ADDR_BITS = 16;
    localparam logic [15:0] ADDR_MASK = 16'((32'd1 << MEM_ADDR_BITS) - 1);

    // Codes the package leaves unnamed: the spare opcode and the reserved modes
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [2:0] AM_RSVD_3 = 3'd3;
    localparam logic [2:0] AM_RSVD_4 = 3'd4;
    localparam logic [2:0] AM_RSVD_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1700;

    // One instruction as driven on the request ports
    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] addr_mode;
        logic       byte_size;
        logic [2:0] source_reg;
        logic [2:0] dest_reg;
        logic [5:0] offset6;
        logic [7:0] imm_byte;
    } lsmu_item_t;

    // One result as strobed on done
    typedef struct packed {
        logic [15:0] eff_addr;
        logic [15:0] mem_value;
        logic [15:0] dest_value;
        logic [15:0] base_value;
        logic        executed;
    } lsmu_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  operation;
    logic [2:0]  addr_mode;
    logic        byte_size;
    logic [2:0]  source_reg;
    logic [2:0]  dest_reg;
    logic [5:0]  offset6;
    logic [7:0]  imm_byte;
    logic        done;
    logic [15:0] eff_addr;
    logic [15:0] mem_value;
    logic [15:0] dest_value;
    logic [15:0] base_value;
    logic        executed;

    // Shadow copy of the machine state, updated as each transaction is accepted
    logic [15:0]  shadow_regs [NUM_REGS];
    logic [7:0]   shadow_mem [bit [15:0]];
    lsmu_result_t expected_results [$];

    int failure_count   = 0;
    int items_sent      = 0;
    int sender_idle_pct = 17;

    load_store_move_unit #(
        .NUM_REGS      (NUM_REGS),
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .addr_mode  (addr_mode),
        .byte_size  (byte_size),
        .source_reg (source_reg),
        .dest_reg   (dest_reg),
        .offset6    (offset6),
        .imm_byte   (imm_byte),
        .done       (done),
        .eff_addr   (eff_addr),
        .mem_value  (mem_value),
        .dest_value (dest_value),
        .base_value (base_value),
        .executed   (executed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result
    initial
    begin
        #(2_000_000);
        $display("load_store_move_unit verification failed");
        $finish;
    end

    function automatic void report_failure(string msg);
        failure_count++;
        if (failure_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic bit mode_is_valid(logic [2:0] mode);
        return mode == AM_NONE || mode == AM_POSTINC || mode == AM_POSTDEC ||
               mode == AM_PREINC || mode == AM_PREDEC;
    endfunction

    function automatic logic [15:0] read_shadow(logic [15:0] addr, logic is_byte);
        logic [15:0] lo_addr;
        logic [15:0] hi_addr;
        lo_addr = addr & ADDR_MASK;
        hi_addr = (addr + 16'd1) & ADDR_MASK;
        if (is_byte)
            return {8'h00, shadow_mem[lo_addr]};
        return {shadow_mem[hi_addr], shadow_mem[lo_addr]};
    endfunction

    function automatic void write_shadow(logic [15:0] addr, logic [15:0] data, logic is_byte);
        shadow_mem[addr & ADDR_MASK] = data[7:0];
        if (!is_byte)
            shadow_mem[(addr + 16'd1) & ADDR_MASK] = data[15:8];
    endfunction

    function automatic void step_pointer(logic [2:0] idx, logic down, logic [15:0] amount);
        if (down)
            shadow_regs[idx] = shadow_regs[idx] - amount;
        else
            shadow_regs[idx] = shadow_regs[idx] + amount;
    endfunction

    // Byte loads keep the high byte of the destination
    function automatic void load_register(logic [2:0] idx, logic [15:0] data, logic is_byte);
        if (is_byte)
            shadow_regs[idx] = {shadow_regs[idx][15:8], data[7:0]};
        else
            shadow_regs[idx] = data;
    endfunction

    function automatic logic [15:0] store_data(lsmu_item_t it);
        if (it.byte_size)
            return {8'h00, shadow_regs[it.source_reg][7:0]};
        return shadow_regs[it.source_reg];
    endfunction

    // True when the load would touch a memory byte that was never stored
    function automatic bit touches_unwritten(lsmu_item_t it);
        logic [15:0] addr;
        logic [15:0] amount;
        amount = it.byte_size ? BYTE_STEP : WORD_STEP;
        if (it.operation == OP_LD && mode_is_valid(it.addr_mode))
        begin
            addr = shadow_regs[it.source_reg];
            if (it.addr_mode[2])
                addr = it.addr_mode[1] ? addr - amount : addr + amount;
        end
        else if (it.operation == OP_LDR)
        begin
            addr = shadow_regs[it.source_reg] + {{10{it.offset6[5]}}, it.offset6};
        end
        else
        begin
            return 1'b0;
        end
        return !shadow_mem.exists(addr & ADDR_MASK) ||
               (!it.byte_size && !shadow_mem.exists((addr + 16'd1) & ADDR_MASK));
    endfunction

    // Execute one instruction on the shadow state and return its result
    function automatic lsmu_result_t execute_instruction(lsmu_item_t it);
        lsmu_result_t res;
        logic [15:0]  amount;
        logic [15:0]  disp;
        logic [15:0]  ea;
        logic [2:0]   ptr;
        logic         modify;
        res = '0;
        res.executed = 1'b1;
        amount = it.byte_size ? BYTE_STEP : WORD_STEP;
        disp = {{10{it.offset6[5]}}, it.offset6};
        case (it.operation)
            OP_LD, OP_ST:
            begin
                if (!mode_is_valid(it.addr_mode))
                begin
                    res.executed = 1'b0;
                end
                else
                begin
                    ptr = (it.operation == OP_LD) ? it.source_reg : it.dest_reg;
                    modify = (it.addr_mode != AM_NONE);
                    // pre modes move the pointer before the access, post modes after it
                    if (modify && it.addr_mode[2])
                        step_pointer(ptr, it.addr_mode[1], amount);
                    ea = shadow_regs[ptr] & ADDR_MASK;
                    if (it.operation == OP_LD)
                    begin
                        res.mem_value = read_shadow(ea, it.byte_size);
                        load_register(it.dest_reg, res.mem_value, it.byte_size);
                    end
                    else
                    begin
                        res.mem_value = store_data(it);
                        write_shadow(ea, res.mem_value, it.byte_size);
                    end
                    if (modify && !it.addr_mode[2])
                        step_pointer(ptr, it.addr_mode[1], amount);
                    res.eff_addr   = ea;
                    res.dest_value = shadow_regs[it.dest_reg];
                    res.base_value = shadow_regs[ptr];
                end
            end
            OP_LDR:
            begin
                ea = (shadow_regs[it.source_reg] + disp) & ADDR_MASK;
                res.mem_value = read_shadow(ea, it.byte_size);
                load_register(it.dest_reg, res.mem_value, it.byte_size);
                res.eff_addr   = ea;
                res.dest_value = shadow_regs[it.dest_reg];
                res.base_value = shadow_regs[it.source_reg];
            end
            OP_STR:
            begin
                ea = (shadow_regs[it.dest_reg] + disp) & ADDR_MASK;
                res.mem_value = store_data(it);
                write_shadow(ea, res.mem_value, it.byte_size);
                res.eff_addr   = ea;
                res.dest_value = shadow_regs[it.dest_reg];
                res.base_value = shadow_regs[it.dest_reg];
            end
            OP_MOVL:
            begin
                shadow_regs[it.dest_reg] = {shadow_regs[it.dest_reg][15:8], it.imm_byte};
                res.dest_value = shadow_regs[it.dest_reg];
            end
            OP_MOVLZ:
            begin
                shadow_regs[it.dest_reg] = {8'h00, it.imm_byte};
                res.dest_value = shadow_regs[it.dest_reg];
            end
            OP_MOVH:
            begin
                shadow_regs[it.dest_reg] = {it.imm_byte, shadow_regs[it.dest_reg][7:0]};
                res.dest_value = shadow_regs[it.dest_reg];
            end
            default:
            begin
                res.executed = 1'b0;
            end
        endcase
        return res;
    endfunction

    function automatic lsmu_item_t make_item(logic [2:0] op, logic [2:0] mode, logic is_byte,
                                             logic [2:0] src, logic [2:0] dst,
                                             logic [5:0] off, logic [7:0] imm);
        lsmu_item_t it;
        it.operation  = op;
        it.addr_mode  = mode;
        it.byte_size  = is_byte;
        it.source_reg = src;
        it.dest_reg   = dst;
        it.offset6    = off;
        it.imm_byte   = imm;
        return it;
    endfunction

    function automatic lsmu_item_t random_fields();
        lsmu_item_t it;
        it.operation  = 3'($urandom);
        it.addr_mode  = 3'($urandom);
        it.byte_size  = 1'($urandom);
        it.source_reg = 3'($urandom);
        it.dest_reg   = 3'($urandom);
        it.offset6    = 6'($urandom);
        it.imm_byte   = 8'($urandom);
        return it;
    endfunction

    function automatic logic [2:0] random_valid_mode();
        case ($urandom_range(0, 4))
            0: return AM_NONE;
            1: return AM_POSTINC;
            2: return AM_POSTDEC;
            3: return AM_PREINC;
            default: return AM_PREDEC;
        endcase
    endfunction

    // Drive one transaction and hold it until the block takes it. Inputs change on
    // the falling edge; busy is sampled on the rising edge. A load that would read
    // never-stored memory is turned into the store to the same address instead.
    task automatic send_instruction(input lsmu_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        if (touches_unwritten(it))
        begin
            it.operation  = (it.operation == OP_LD) ? OP_ST : OP_STR;
            it.dest_reg   = it.source_reg;
            it.source_reg = 3'($urandom);
        end
        start      <= 1'b1;
        operation  <= it.operation;
        addr_mode  <= it.addr_mode;
        byte_size  <= it.byte_size;
        source_reg <= it.source_reg;
        dest_reg   <= it.dest_reg;
        offset6    <= it.offset6;
        imm_byte   <= it.imm_byte;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        expected_results.push_back(execute_instruction(it));
        items_sent++;
    endtask

    // Compare every strobed result against the oldest prediction
    always @(posedge clk)
    begin : result_check
        lsmu_result_t seen;
        lsmu_result_t wanted;
        if (rst_n && done)
        begin
            seen.eff_addr   = eff_addr;
            seen.mem_value  = mem_value;
            seen.dest_value = dest_value;
            seen.base_value = base_value;
            seen.executed   = executed;
            if (expected_results.size() == 0)
            begin
                report_failure($sformatf(
                    "unexpected result at %0t: addr=%h mem=%h dest=%h base=%h exec=%b",
                    $realtime, seen.eff_addr, seen.mem_value, seen.dest_value,
                    seen.base_value, seen.executed));
            end
            else
            begin
                wanted = expected_results.pop_front();
                if (seen !== wanted)
                    report_failure($sformatf({"mismatch at %0t: expected addr=%h mem=%h dest=%h ",
                                   "base=%h exec=%b, got addr=%h mem=%h dest=%h base=%h exec=%b"},
                                   $realtime, wanted.eff_addr, wanted.mem_value,
                                   wanted.dest_value, wanted.base_value, wanted.executed,
                                   seen.eff_addr, seen.mem_value, seen.dest_value,
                                   seen.base_value, seen.executed));
            end
        end
    end

    // Byte moves at the extremes of the immediate
    task automatic test_byte_moves();
        send_instruction(make_item(OP_MOVLZ, AM_NONE, 1'b0, 3'd0, 3'd0, 6'd0, 8'hFF));
        send_instruction(make_item(OP_MOVH, AM_NONE, 1'b0, 3'd0, 3'd0, 6'd0, 8'hFF));
        send_instruction(make_item(OP_MOVL, AM_NONE, 1'b0, 3'd0, 3'd0, 6'd0, 8'h00));
    endtask

    // LD/ST in every mode, wrap at the top of memory, pointer equal to data register
    task automatic test_pointer_modes();
        // r1 = 0xFFFF points at the last byte, r2 = 0x1234 holds data
        send_instruction(make_item(OP_MOVLZ, AM_NONE, 1'b0, 3'd0, 3'd1, 6'd0, 8'hFF));
        send_instruction(make_item(OP_MOVH, AM_NONE, 1'b0, 3'd0, 3'd1, 6'd0, 8'hFF));
        send_instruction(make_item(OP_MOVLZ, AM_NONE, 1'b0, 3'd0, 3'd2, 6'd0, 8'h34));
        send_instruction(make_item(OP_MOVH, AM_NONE, 1'b0, 3'd0, 3'd2, 6'd0, 8'h12));
        // word straddling the wrap, read back with post-increment then pre-decrement
        send_instruction(make_item(OP_ST, AM_NONE, 1'b0, 3'd2, 3'd1, 6'd0, 8'd0));
        send_instruction(make_item(OP_LD, AM_POSTINC, 1'b0, 3'd1, 3'd3, 6'd0, 8'd0));
        send_instruction(make_item(OP_LD, AM_PREDEC, 1'b0, 3'd1, 3'd4, 6'd0, 8'd0));
        send_instruction(make_item(OP_ST, AM_PREINC, 1'b1, 3'd2, 3'd1, 6'd0, 8'd0));
        // byte load into a register whose high byte is set
        send_instruction(make_item(OP_LD, AM_POSTDEC, 1'b1, 3'd1, 3'd0, 6'd0, 8'd0));
        // pointer is also the data register: pre mode stores the moved value
        send_instruction(make_item(OP_ST, AM_PREDEC, 1'b0, 3'd1, 3'd1, 6'd0, 8'd0));
        send_instruction(make_item(OP_ST, AM_POSTINC, 1'b0, 3'd1, 3'd1, 6'd0, 8'd0));
        // post-increment load into its own pointer: the increment wins
        send_instruction(make_item(OP_LD, AM_POSTINC, 1'b0, 3'd1, 3'd1, 6'd0, 8'd0));
        // reserved modes do nothing
        send_instruction(make_item(OP_LD, AM_RSVD_3, 1'b0, 3'd1, 3'd2, 6'd0, 8'd0));
        send_instruction(make_item(OP_ST, AM_RSVD_4, 1'b1, 3'd2, 3'd1, 6'd0, 8'd0));
        send_instruction(make_item(OP_LD, AM_RSVD_7, 1'b1, 3'd1, 3'd2, 6'd0, 8'd0));
    endtask

    // LDR/STR at the largest positive and negative offsets, and a store at offset -1
    task automatic test_offset_access();
        send_instruction(make_item(OP_STR, AM_NONE, 1'b0, 3'd2, 3'd5, 6'h1F, 8'd0));
        send_instruction(make_item(OP_LDR, AM_NONE, 1'b0, 3'd5, 3'd6, 6'h1F, 8'd0));
        send_instruction(make_item(OP_STR, AM_NONE, 1'b1, 3'd2, 3'd5, 6'h20, 8'd0));
        send_instruction(make_item(OP_LDR, AM_NONE, 1'b1, 3'd5, 3'd6, 6'h20, 8'd0));
        send_instruction(make_item(OP_STR, AM_NONE, 1'b0, 3'd4, 3'd5, 6'h3F, 8'd0));
    endtask

    task automatic test_unused_opcode();
        send_instruction(make_item(OP_UNUSED, AM_RSVD_7, 1'b1, 3'd7, 3'd7, 6'h3F, 8'hFF));
    endtask

    // Point a register somewhere, store through it, then load back through it
    task automatic send_pointer_burst();
        lsmu_item_t it;
        logic [2:0] ptr;
        logic [7:0] hi;
        ptr = 3'($urandom);
        hi  = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
        send_instruction(make_item(OP_MOVLZ, AM_NONE, 1'b0, 3'd0, ptr, 6'd0, 8'($urandom)));
        send_instruction(make_item(OP_MOVH, AM_NONE, 1'b0, 3'd0, ptr, 6'd0, hi));
        repeat ($urandom_range(2, 6))
        begin
            it = random_fields();
            it.operation = ($urandom_range(0, 3) == 0) ? OP_STR : OP_ST;
            it.addr_mode = random_valid_mode();
            it.dest_reg  = ptr;
            send_instruction(it);
        end
        repeat ($urandom_range(2, 6))
        begin
            it = random_fields();
            it.operation  = ($urandom_range(0, 3) == 0) ? OP_LDR : OP_LD;
            it.addr_mode  = random_valid_mode();
            it.source_reg = ptr;
            send_instruction(it);
        end
    endtask

    // Mostly store/load bursts, with loose moves and fully random instructions
    task automatic test_random_traffic();
        lsmu_item_t it;
        int         phase_end;
        int         pick;
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 88 : 0;
            phase_end = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    it = random_fields();
                    it.operation = 3'($urandom_range(OP_MOVL, OP_MOVH));
                    send_instruction(it);
                end
                else if (pick < 22)
                begin
                    send_instruction(random_fields());
                end
                else
                begin
                    send_pointer_burst();
                end
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = 3'd0;
        addr_mode  = 3'd0;
        byte_size  = 1'b0;
        source_reg = 3'd0;
        dest_reg   = 3'd0;
        offset6    = 6'd0;
        imm_byte   = 8'd0;
        foreach (shadow_regs[i])
            shadow_regs[i] = 16'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_byte_moves();
        test_pointer_modes();
        test_offset_access();
        test_unused_opcode();
        test_random_traffic();

        // Drop start, drain outstanding results, then wait for strays before the final check
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (failure_count == 0 && expected_results.size() == 0)
            $display("load_store_move_unit verification clean");
        else
            $display("load_store_move_unit verification failed");
        $finish;
    end

endmodule
